@@ hw/rtl/tds_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tds_pkg
// Shared constants and types for the tridiagonal system solver.
// ----------------------------------------------------------------------------
package tds_pkg;

  localparam int MaxRowsDef  = 64;
  localparam int FracBitsDef = 16;
  localparam int RowW        = 6;
  localparam int DataW       = 32;

  localparam logic signed [DataW-1:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] QMin = 32'sh8000_0000;

  // one row beat handed from the front end to the elimination engine
  typedef struct packed {
    logic signed [DataW-1:0] sub_diag;
    logic signed [DataW-1:0] main_diag;
    logic signed [DataW-1:0] super_diag;
    logic signed [DataW-1:0] rhs_value;
    logic [RowW-1:0]         row;
    logic                    first;
    logic                    last;
    logic                    ovf;
  } row_beat_t;

  // saturate a 66 bit value to 32 bit signed
  function automatic logic signed [DataW-1:0] sat66(input logic signed [65:0] v);
    logic signed [DataW-1:0] r;
    r = v[DataW-1:0];
    if (v > 66'sh0_7FFF_FFFF) begin
      r = QMax;
    end else if (v < -66'sh0_8000_0000) begin
      r = QMin;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/tds_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tds_front
// Accepts row beats, numbers them, classifies first/last/overflow and pushes
// them into a two-entry queue towards the elimination engine.
// ----------------------------------------------------------------------------
module tds_front #(
  parameter int MAX_ROWS = tds_pkg::MaxRowsDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [tds_pkg::DataW-1:0] in_sub_diag,
  input  logic signed [tds_pkg::DataW-1:0] in_main_diag,
  input  logic signed [tds_pkg::DataW-1:0] in_super_diag,
  input  logic signed [tds_pkg::DataW-1:0] in_rhs_value,
  input  logic                            in_last_row,
  output logic                            q_valid,
  output tds_pkg::row_beat_t              q_beat,
  input  logic                            q_pop,
  input  logic                            solve_done
);

  localparam logic [tds_pkg::RowW:0] LastIdx = (tds_pkg::RowW+1)'(MAX_ROWS - 1);

  tds_pkg::row_beat_t q_r [2];
  logic [1:0] wp_r, rp_r;
  logic [tds_pkg::RowW:0] cnt_r;
  logic hold_r; // a last row is queued, wait for back substitution to finish
  logic full, last, push;

  assign full = (wp_r - rp_r) == 2'd2;
  assign busy = full || hold_r;
  assign push = start && !busy;
  assign last = in_last_row || (cnt_r == LastIdx);
  assign q_valid = wp_r != rp_r;
  assign q_beat = q_r[rp_r[0]];

  // row numbering and queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; hold_r <= 1'b0;
    end else begin
      if (push) begin
        q_r[wp_r[0]] <= '{sub_diag: in_sub_diag, main_diag: in_main_diag,
                          super_diag: in_super_diag, rhs_value: in_rhs_value,
                          row: cnt_r[tds_pkg::RowW-1:0], first: cnt_r == '0,
                          last: last, ovf: last && !in_last_row};
        wp_r <= wp_r + 2'd1;
        cnt_r <= last ? '0 : cnt_r + 1'b1;
        if (last) hold_r <= 1'b1;
      end
      if (q_pop) rp_r <= rp_r + 2'd1;
      if (solve_done) hold_r <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) (wp_r - rp_r) <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= LastIdx)
    else $error("row count past store");
  assert property (@(posedge clk) disable iff (!rst_n) push && last |=> busy)
    else $error("front took a row after a last row");

endmodule

@@ hw/rtl/tds_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tds_div
// Radix-2 restoring divider: (num << FRAC_BITS) / den, truncated toward zero,
// saturated to 32 bit signed; zero divisor gives zero.
// ----------------------------------------------------------------------------
module tds_div #(
  parameter int FRAC_BITS = tds_pkg::FracBitsDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            go,
  input  logic signed [tds_pkg::DataW-1:0] num,
  input  logic signed [tds_pkg::DataW-1:0] den,
  output logic                            done,
  output logic signed [tds_pkg::DataW-1:0] quo
);

  localparam int NW = tds_pkg::DataW + FRAC_BITS; // dividend magnitude bits
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dvd_r, q_r;
  logic [tds_pkg::DataW:0] rem_r, dsr_r;
  logic [CW-1:0] cnt_r;
  logic run_r, neg_r, zero_r;
  logic [tds_pkg::DataW+1:0] trial;
  logic [tds_pkg::DataW:0] rsh;

  assign rsh = {rem_r[tds_pkg::DataW-1:0], dvd_r[NW-1]};
  assign trial = {1'b0, rsh} - {1'b0, dsr_r};

  logic signed [NW+1:0] sq;
  assign sq = neg_r ? -$signed({2'b00, q_r}) : $signed({2'b00, q_r});

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        dvd_r  <= NW'(num[tds_pkg::DataW-1] ? -{{(NW-tds_pkg::DataW){num[31]}}, num}
                                            :  {{(NW-tds_pkg::DataW){1'b0}}, num})
                  << FRAC_BITS;
        dsr_r  <= den[31] ? -{1'b1, den} : {1'b0, den};
        neg_r  <= num[31] ^ den[31];
        zero_r <= den == '0;
        rem_r  <= '0; q_r <= '0; cnt_r <= CW'(NW); run_r <= 1'b1;
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r <= 1'b0; done <= 1'b1;
          if (zero_r) quo <= '0;
          else if (sq > $signed((NW+2)'(tds_pkg::QMax))) quo <= tds_pkg::QMax;
          else if (sq < -$signed((NW+2)'(33'sh0_8000_0000))) quo <= tds_pkg::QMin;
          else quo <= sq[tds_pkg::DataW-1:0];
        end else begin
          dvd_r <= dvd_r << 1;
          cnt_r <= cnt_r - 1'b1;
          if (!trial[tds_pkg::DataW+1]) begin
            rem_r <= trial[tds_pkg::DataW:0];
            q_r <= {q_r[NW-2:0], 1'b1};
          end else begin
            rem_r <= rsh;
            q_r <= {q_r[NW-2:0], 1'b0};
          end
        end
      end
    end
  end

endmodule

@@ hw/rtl/tds_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tds_back
// Elimination engine: forms each pivot, divides, stores modified super and
// rhs values, then runs back substitution and emits the solutions.
// ----------------------------------------------------------------------------
module tds_back #(
  parameter int MAX_ROWS  = tds_pkg::MaxRowsDef,
  parameter int FRAC_BITS = tds_pkg::FracBitsDef
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  tds_pkg::row_beat_t               q_beat,
  output logic                             q_pop,
  output logic                             solve_done,
  output logic                             out_valid,
  output logic signed [tds_pkg::DataW-1:0] out_solution,
  output logic [tds_pkg::RowW-1:0]         out_row_index,
  output logic                             out_singular,
  output logic                             out_overflowed,
  output logic                             out_last_result
);

  localparam int AW = $clog2(MAX_ROWS);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MUL, S_SUM, S_DIVS, S_WAITS, S_DIVR, S_WAITR,
    S_BRD, S_BMUL, S_BOUT
  } state_t;

  state_t st_r;
  tds_pkg::row_beat_t b_r;
  logic signed [tds_pkg::DataW-1:0] sup_mem [MAX_ROWS];
  logic signed [tds_pkg::DataW-1:0] rhs_mem [MAX_ROWS];
  logic signed [tds_pkg::DataW-1:0] rs_r, rr_r, piv_r, num_r, csup_r, x_r;
  logic signed [63:0] p1_r, p2_r;
  logic [tds_pkg::RowW-1:0] idx_r;
  logic sing_r, first_out_r;
  logic dgo;
  logic signed [tds_pkg::DataW-1:0] dnum, dq;
  logic ddone;

  // floor shift of a product
  function automatic logic signed [65:0] fsh(input logic signed [63:0] p);
    return 66'(p >>> FRAC_BITS);
  endfunction

  assign dnum = (st_r == S_DIVS) ? b_r.super_diag : num_r;
  assign dgo  = (st_r == S_DIVS) || (st_r == S_DIVR);

  tds_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .go(dgo), .num(dnum), .den(piv_r),
    .done(ddone), .quo(dq)
  );

  assign q_pop = (st_r == S_IDLE) && q_valid;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; sing_r <= 1'b0; out_valid <= 1'b0; solve_done <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      solve_done <= 1'b0;
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          b_r <= q_beat; st_r <= S_RD;
        end
        S_RD: begin
          rs_r <= sup_mem[AW'(b_r.row - 1'b1)];
          rr_r <= rhs_mem[AW'(b_r.row - 1'b1)];
          st_r <= S_MUL;
        end
        S_MUL: begin
          p1_r <= 64'(b_r.sub_diag) * 64'(rs_r);
          p2_r <= 64'(b_r.sub_diag) * 64'(rr_r);
          st_r <= S_SUM;
        end
        S_SUM: begin
          if (b_r.first) begin
            piv_r <= b_r.main_diag; num_r <= b_r.rhs_value;
          end else begin
            piv_r <= tds_pkg::sat66(66'(b_r.main_diag) - fsh(p1_r));
            num_r <= tds_pkg::sat66(66'(b_r.rhs_value) - fsh(p2_r));
          end
          st_r <= S_DIVS;
        end
        S_DIVS: begin
          if (piv_r == '0) sing_r <= 1'b1;
          st_r <= S_WAITS;
        end
        S_WAITS: if (ddone) begin
          csup_r <= b_r.last ? '0 : dq; st_r <= S_DIVR;
        end
        S_DIVR: st_r <= S_WAITR;
        S_WAITR: if (ddone) begin
          sup_mem[AW'(b_r.row)] <= csup_r;
          rhs_mem[AW'(b_r.row)] <= dq;
          if (b_r.last) begin
            idx_r <= b_r.row; first_out_r <= 1'b1; st_r <= S_BRD;
          end else begin
            st_r <= S_IDLE;
          end
        end
        S_BRD: begin
          rs_r <= sup_mem[AW'(idx_r)];
          rr_r <= rhs_mem[AW'(idx_r)];
          st_r <= S_BMUL;
        end
        S_BMUL: begin
          p1_r <= 64'(rs_r) * 64'(x_r);
          st_r <= S_BOUT;
        end
        S_BOUT: begin
          logic signed [tds_pkg::DataW-1:0] xv;
          xv = first_out_r ? rr_r : tds_pkg::sat66(66'(rr_r) - fsh(p1_r));
          x_r <= xv;
          first_out_r <= 1'b0;
          out_valid <= 1'b1;
          out_solution <= xv;
          out_row_index <= idx_r;
          out_singular <= sing_r;
          out_overflowed <= b_r.ovf;
          out_last_result <= idx_r == '0;
          if (idx_r == '0) begin
            st_r <= S_IDLE; sing_r <= 1'b0; solve_done <= 1'b1;
          end else begin
            idx_r <= idx_r - 1'b1; st_r <= S_BRD;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) solve_done |-> out_valid && out_last_result)
    else $error("solve ended without row zero result");
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> st_r == S_RD)
    else $error("popped beat not taken");
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> $past(st_r) == S_BOUT)
    else $error("result outside substitution");

endmodule

@@ hw/rtl/tridiagonal_system_solver_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tridiagonal_system_solver_core
// Thomas algorithm tridiagonal solver, signed fixed point Q.FRAC_BITS.
// ----------------------------------------------------------------------------
// Usage: drive one row beat on in_* with start high; it is taken when busy is
// low. Rows are numbered from zero in arrival order; in_last_row (or the row
// that fills the MAX_ROWS store) ends the system. In the back end each row is
// paced by the radix-2 divider, which forms both quotients of the row in
// turn; a two-beat queue lets the front take rows while the back end divides.
// After the last row, the solutions leave on out_* from the highest row down
// to row zero, each marked by out_valid for one cycle; out_last_result flags
// row zero. The receiver cannot stall. busy stays high from a last row until
// its final result. Reset clears the control state and starts a new system at
// row zero; the row stores need no clearing.
// ----------------------------------------------------------------------------
module tridiagonal_system_solver_core #(
  parameter int MAX_ROWS  = tds_pkg::MaxRowsDef,
  parameter int FRAC_BITS = tds_pkg::FracBitsDef
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [tds_pkg::DataW-1:0] in_sub_diag,
  input  logic signed [tds_pkg::DataW-1:0] in_main_diag,
  input  logic signed [tds_pkg::DataW-1:0] in_super_diag,
  input  logic signed [tds_pkg::DataW-1:0] in_rhs_value,
  input  logic                             in_last_row,
  output logic                             out_valid,
  output logic signed [tds_pkg::DataW-1:0] out_solution,
  output logic [tds_pkg::RowW-1:0]         out_row_index,
  output logic                             out_singular,
  output logic                             out_overflowed,
  output logic                             out_last_result
);

  logic q_valid, q_pop, solve_done;
  tds_pkg::row_beat_t q_beat;

  // front end: accept and classify rows
  tds_front #(.MAX_ROWS(MAX_ROWS)) u_front (
    .clk, .rst_n, .start, .busy, .in_sub_diag, .in_main_diag, .in_super_diag,
    .in_rhs_value, .in_last_row, .q_valid, .q_beat, .q_pop, .solve_done
  );

  // back end: elimination and back substitution
  tds_back #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_beat, .q_pop, .solve_done, .out_valid,
    .out_solution, .out_row_index, .out_singular, .out_overflowed,
    .out_last_result
  );

endmodule
